>>> sv/ts_cc_pkg.sv
// Shared types and codes for the transport-stream continuity checker.
package ts_cc_pkg;

  localparam logic [12:0] NULL_PID = 13'h1FFF;

  typedef enum logic [1:0] {
    CMD_CHECK = 2'd0,
    CMD_CLEAR = 2'd1,
    CMD_READ  = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    STAT_KNOWN   = 3'd0,
    STAT_NEW     = 3'd1,
    STAT_FULL    = 3'd2,
    STAT_CLEARED = 3'd3,
    STAT_RD_OK   = 3'd4,
    STAT_RD_NONE = 3'd5
  } status_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_HIT,
    ST_READ
  } state_t;

  typedef struct packed {
    logic [12:0] pid;
    logic [3:0]  last_cc;
    logic [31:0] packets;
    logic [31:0] discs;
  } entry_t;

endpackage

>>> sv/ts_continuity_checker.sv
// Top level of the transport-stream continuity checker.
// A check transaction walks the PID table one entry per cycle through a single PID comparator
// and the table's one read port: busy stays high while it scans the entries up to the first
// one that holds the PID, plus an update state on a hit, or all filled entries on a miss.
// A read transaction raises busy for its read state; clear and the unused command answer from
// idle with busy never raised. Each transaction gives exactly one result, shown for one cycle
// with out_valid and not held back by the receiver; busy is already low in that cycle, so start
// may come back at once. Entries are filled in order, so a fill count marks which are in use
// and clear only has to reset that count. Write the watch registers only while busy is low.
module ts_continuity_checker #(
  parameter int TABLE_ENTRIES = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_command,
  input  logic [12:0] in_pid,
  input  logic [3:0]  in_cc,
  input  logic [5:0]  in_read_index,
  output logic        out_valid,
  output logic [2:0]  out_status,
  output logic [5:0]  out_entry_index,
  output logic [12:0] out_entry_pid,
  output logic        out_discontinuity,
  output logic [31:0] out_entry_packets,
  output logic [31:0] out_entry_discontinuities,
  output logic [31:0] out_total_packets,
  output logic [2:0]  out_watch_class,
  output logic [31:0] out_watch_count,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [12:0] cfg_wdata
);

  localparam int IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int CW = $clog2(TABLE_ENTRIES + 1);
  localparam int KW = (CW > 6) ? CW : 6;

  ts_cc_pkg::state_t state_r, state_nxt;
  logic [CW-1:0]     idx_r, idx_nxt;
  logic [CW-1:0]     fill_r, fill_nxt;
  logic [12:0]       pid_r, pid_nxt;
  logic [3:0]        cc_r, cc_nxt;
  logic [5:0]        ridx_r, ridx_nxt;
  logic              rd_ok_r, rd_ok_nxt;
  logic [31:0]       total_r, total_nxt;
  logic [31:0]       wcnt_r [4];
  logic [31:0]       wcnt_nxt [4];
  logic [12:0]       wpid_r [4];

  logic              ov_r, ov_nxt;
  logic [2:0]        ostat_r, ostat_nxt;
  logic [5:0]        oidx_r, oidx_nxt;
  logic [12:0]       opid_r, opid_nxt;
  logic              odisc_r, odisc_nxt;
  logic [31:0]       opkt_r, opkt_nxt;
  logic [31:0]       odcnt_r, odcnt_nxt;
  logic [31:0]       otot_r, otot_nxt;
  logic [2:0]        ocls_r, ocls_nxt;
  logic [31:0]       owcnt_r, owcnt_nxt;

  logic              accept;
  logic              pid_match;
  logic              cc_break;
  logic [KW-1:0]     ridx_k;
  logic [KW-1:0]     fill_k;
  logic              wr_en;
  logic [IW-1:0]     wr_addr;
  logic [IW-1:0]     rd_addr;
  ts_cc_pkg::entry_t wr_data;
  ts_cc_pkg::entry_t rd_data;
  logic              w_any;
  logic [1:0]        w_sel;

  ts_cc_table #(
    .DEPTH (TABLE_ENTRIES),
    .AW    (IW)
  ) u_table (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign busy   = (state_r != ts_cc_pkg::ST_IDLE);
  assign accept = start && !busy;

  assign ridx_k    = KW'(in_read_index);
  assign fill_k    = KW'(fill_r);
  assign pid_match = (rd_data.pid == pid_r);
  assign cc_break  = ((rd_data.last_cc + 4'd1) != cc_r) && (pid_r != ts_cc_pkg::NULL_PID);

  // First matching watch register wins.
  always_comb begin
    w_any = 1'b1;
    priority if (wpid_r[0] == pid_r) w_sel = 2'd0;
    else if (wpid_r[1] == pid_r)     w_sel = 2'd1;
    else if (wpid_r[2] == pid_r)     w_sel = 2'd2;
    else if (wpid_r[3] == pid_r)     w_sel = 2'd3;
    else begin
      w_sel = 2'd0;
      w_any = 1'b0;
    end
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ts_cc_pkg::ST_IDLE: begin
        if (accept && in_command == ts_cc_pkg::CMD_CHECK) begin
          state_nxt = ts_cc_pkg::ST_SCAN;
        end else if (accept && in_command == ts_cc_pkg::CMD_READ) begin
          state_nxt = ts_cc_pkg::ST_READ;
        end
      end
      ts_cc_pkg::ST_SCAN: begin
        if (idx_r == fill_r) begin
          state_nxt = ts_cc_pkg::ST_IDLE;
        end else if (pid_match) begin
          state_nxt = ts_cc_pkg::ST_HIT;
        end
      end
      ts_cc_pkg::ST_HIT:  state_nxt = ts_cc_pkg::ST_IDLE;
      ts_cc_pkg::ST_READ: state_nxt = ts_cc_pkg::ST_IDLE;
      default:            state_nxt = ts_cc_pkg::ST_IDLE;
    endcase
  end

  // Datapath, table access and result.
  always_comb begin
    idx_nxt   = idx_r;
    fill_nxt  = fill_r;
    pid_nxt   = pid_r;
    cc_nxt    = cc_r;
    ridx_nxt  = ridx_r;
    rd_ok_nxt = rd_ok_r;
    total_nxt = total_r;
    for (int w = 0; w < 4; w++) begin
      wcnt_nxt[w] = wcnt_r[w];
    end
    wr_en   = 1'b0;
    wr_addr = idx_r[IW-1:0];
    wr_data = rd_data;
    rd_addr = idx_r[IW-1:0];

    ov_nxt    = 1'b0;
    ostat_nxt = 3'(ts_cc_pkg::STAT_RD_NONE);
    oidx_nxt  = '0;
    opid_nxt  = '0;
    odisc_nxt = 1'b0;
    opkt_nxt  = '0;
    odcnt_nxt = '0;
    otot_nxt  = '0;
    ocls_nxt  = '0;
    owcnt_nxt = '0;

    unique case (state_r)
      ts_cc_pkg::ST_IDLE: begin
        rd_addr = '0;
        if (accept) begin
          unique case (in_command)
            ts_cc_pkg::CMD_CHECK: begin
              pid_nxt   = in_pid;
              cc_nxt    = in_cc;
              idx_nxt   = '0;
              total_nxt = total_r + 32'd1;
            end
            ts_cc_pkg::CMD_CLEAR: begin
              fill_nxt  = '0;
              total_nxt = '0;
              for (int w = 0; w < 4; w++) begin
                wcnt_nxt[w] = '0;
              end
              ov_nxt    = 1'b1;
              ostat_nxt = 3'(ts_cc_pkg::STAT_CLEARED);
            end
            ts_cc_pkg::CMD_READ: begin
              rd_addr   = ridx_k[IW-1:0];
              ridx_nxt  = in_read_index;
              rd_ok_nxt = (ridx_k < fill_k);
            end
            ts_cc_pkg::CMD_NONE: begin
              ov_nxt    = 1'b1;
              ostat_nxt = 3'(ts_cc_pkg::STAT_RD_NONE);
            end
            default: ;
          endcase
        end
      end
      ts_cc_pkg::ST_SCAN: begin
        if (idx_r == fill_r) begin
          ov_nxt   = 1'b1;
          opid_nxt = pid_r;
          otot_nxt = total_r;
          if (fill_r != CW'(TABLE_ENTRIES)) begin
            // Miss with room left: append the PID as a new entry.
            wr_en           = 1'b1;
            wr_addr         = fill_r[IW-1:0];
            wr_data.pid     = pid_r;
            wr_data.last_cc = cc_r;
            wr_data.packets = 32'd1;
            wr_data.discs   = '0;
            fill_nxt        = fill_r + CW'(1);
            ostat_nxt       = 3'(ts_cc_pkg::STAT_NEW);
            oidx_nxt        = 6'(fill_r);
            opkt_nxt        = 32'd1;
          end else begin
            ostat_nxt = 3'(ts_cc_pkg::STAT_FULL);
          end
        end else if (!pid_match) begin
          idx_nxt = idx_r + CW'(1);
          rd_addr = idx_nxt[IW-1:0];
        end
      end
      ts_cc_pkg::ST_HIT: begin
        wr_en           = 1'b1;
        wr_data.last_cc = cc_r;
        wr_data.packets = rd_data.packets + 32'd1;
        wr_data.discs   = cc_break ? rd_data.discs + 32'd1 : rd_data.discs;
        if (w_any) begin
          wcnt_nxt[w_sel] = wcnt_r[w_sel] + 32'd1;
          ocls_nxt        = {1'b0, w_sel} + 3'd1;
          owcnt_nxt       = wcnt_r[w_sel] + 32'd1;
        end
        ov_nxt    = 1'b1;
        ostat_nxt = 3'(ts_cc_pkg::STAT_KNOWN);
        oidx_nxt  = 6'(idx_r);
        opid_nxt  = pid_r;
        odisc_nxt = cc_break;
        opkt_nxt  = wr_data.packets;
        odcnt_nxt = wr_data.discs;
        otot_nxt  = total_r;
      end
      ts_cc_pkg::ST_READ: begin
        ov_nxt   = 1'b1;
        oidx_nxt = ridx_r;
        otot_nxt = total_r;
        if (rd_ok_r) begin
          ostat_nxt = 3'(ts_cc_pkg::STAT_RD_OK);
          opid_nxt  = rd_data.pid;
          opkt_nxt  = rd_data.packets;
          odcnt_nxt = rd_data.discs;
        end else begin
          ostat_nxt = 3'(ts_cc_pkg::STAT_RD_NONE);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ts_cc_pkg::ST_IDLE;
      fill_r  <= '0;
      total_r <= '0;
      ov_r    <= 1'b0;
      for (int w = 0; w < 4; w++) begin
        wcnt_r[w] <= '0;
        wpid_r[w] <= '0;
      end
    end else begin
      state_r <= state_nxt;
      fill_r  <= fill_nxt;
      total_r <= total_nxt;
      ov_r    <= ov_nxt;
      for (int w = 0; w < 4; w++) begin
        wcnt_r[w] <= wcnt_nxt[w];
      end
      if (cfg_we) begin
        wpid_r[cfg_index] <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    idx_r   <= idx_nxt;
    pid_r   <= pid_nxt;
    cc_r    <= cc_nxt;
    ridx_r  <= ridx_nxt;
    rd_ok_r <= rd_ok_nxt;
    ostat_r <= ostat_nxt;
    oidx_r  <= oidx_nxt;
    opid_r  <= opid_nxt;
    odisc_r <= odisc_nxt;
    opkt_r  <= opkt_nxt;
    odcnt_r <= odcnt_nxt;
    otot_r  <= otot_nxt;
    ocls_r  <= ocls_nxt;
    owcnt_r <= owcnt_nxt;
  end

  assign out_valid                 = ov_r;
  assign out_status                = ostat_r;
  assign out_entry_index           = oidx_r;
  assign out_entry_pid             = opid_r;
  assign out_discontinuity         = odisc_r;
  assign out_entry_packets         = opkt_r;
  assign out_entry_discontinuities = odcnt_r;
  assign out_total_packets         = otot_r;
  assign out_watch_class           = ocls_r;
  assign out_watch_count           = owcnt_r;

  a_result_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
    ov_r |-> (state_r == ts_cc_pkg::ST_IDLE))
    else $error("result strobe while a transaction is still in progress");

  a_fill_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= CW'(TABLE_ENTRIES))
    else $error("fill count beyond table size");

  a_scan_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ts_cc_pkg::ST_SCAN) |-> (idx_r <= fill_r))
    else $error("scan index passed the filled entries");

  a_check_starts_scan: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_command == ts_cc_pkg::CMD_CHECK) |=> (state_r == ts_cc_pkg::ST_SCAN))
    else $error("check transaction did not start a table scan");

  a_hit_after_scan: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ts_cc_pkg::ST_HIT) |-> ($past(state_r) == ts_cc_pkg::ST_SCAN))
    else $error("entry update without a preceding scan match");

endmodule

>>> sv/ts_cc_table.sv
// PID table storage: one write port and one registered read port.
module ts_cc_table #(
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  logic                clk,
  input  logic                wr_en,
  input  logic [AW-1:0]       wr_addr,
  input  ts_cc_pkg::entry_t   wr_data,
  input  logic [AW-1:0]       rd_addr,
  output ts_cc_pkg::entry_t   rd_data
);

  ts_cc_pkg::entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

>>> test/tb_ts_continuity_checker.sv
// Self-checking testbench for the transport-stream continuity checker.
`timescale 1ns / 1ps

module tb_ts_continuity_checker;

  localparam int TABLE_ENTRIES = 64;
  localparam int RAND_PHASES = 8;
  localparam int PHASE_ITEMS = 200;
  localparam int CALM_AFTER = 1400;
  localparam int MAX_REPORTS = 40;

  typedef struct packed {
    ts_cc_pkg::status_t status;
    logic [5:0]  idx;
    logic [12:0] pid;
    logic        disc;
    logic [31:0] pkts;
    logic [31:0] discs;
    logic [31:0] total;
    logic [2:0]  wclass;
    logic [31:0] wcount;
  } ts_result_t;

  typedef struct {
    ts_cc_pkg::cmd_t cmd;
    logic [12:0] pid;
    logic [3:0]  cc;
    logic [5:0]  ridx;
    bit          typed;
    ts_result_t  res;
  } stim_row_t;

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic [1:0]  in_command;
  logic [12:0] in_pid;
  logic [3:0]  in_cc;
  logic [5:0]  in_read_index;
  logic        out_valid;
  logic [2:0]  out_status;
  logic [5:0]  out_entry_index;
  logic [12:0] out_entry_pid;
  logic        out_discontinuity;
  logic [31:0] out_entry_packets;
  logic [31:0] out_entry_discontinuities;
  logic [31:0] out_total_packets;
  logic [2:0]  out_watch_class;
  logic [31:0] out_watch_count;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [12:0] cfg_wdata;

  // Typed expectation travelling with the transaction on the input side
  logic        cur_typed;
  ts_result_t  cur_res;

  // Predictor state
  bit          tbl_valid [TABLE_ENTRIES];
  logic [12:0] tbl_pid   [TABLE_ENTRIES];
  logic [3:0]  tbl_cc    [TABLE_ENTRIES];
  logic [31:0] tbl_pkts  [TABLE_ENTRIES];
  logic [31:0] tbl_discs [TABLE_ENTRIES];
  logic [31:0] pkt_total;
  logic [31:0] watch_cnt [4];
  logic [12:0] watch_pid_m [4];

  ts_result_t  expected_results [$];
  stim_row_t   dir_rows [$];
  logic [3:0]  seq_cc [8192];
  logic [12:0] pid_pool [$];

  int errors;
  int checked;
  int n_known, n_new, n_full, n_reads, n_clears, n_disc;

  ts_continuity_checker #(.TABLE_ENTRIES(TABLE_ENTRIES)) uut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_command(in_command), .in_pid(in_pid), .in_cc(in_cc),
    .in_read_index(in_read_index),
    .out_valid(out_valid), .out_status(out_status),
    .out_entry_index(out_entry_index), .out_entry_pid(out_entry_pid),
    .out_discontinuity(out_discontinuity), .out_entry_packets(out_entry_packets),
    .out_entry_discontinuities(out_entry_discontinuities),
    .out_total_packets(out_total_packets), .out_watch_class(out_watch_class),
    .out_watch_count(out_watch_count),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  initial clk = 1'b0;
  always #2 clk = ~clk;

  function automatic ts_result_t cc_predict(ts_cc_pkg::cmd_t cmd, logic [12:0] pid,
                                            logic [3:0] cc, logic [5:0] ridx);
    ts_result_t r;
    int hit;
    int slot;
    bit found;
    logic [3:0] nxt;
    r = '0;
    hit = -1;
    slot = -1;
    found = 1'b0;
    case (cmd)
      ts_cc_pkg::CMD_CHECK: begin
        pkt_total++;
        for (int i = 0; i < TABLE_ENTRIES && !found; i++) begin
          if (!tbl_valid[i]) begin
            slot = i;
            found = 1'b1;
          end else if (tbl_pid[i] == pid) begin
            hit = i;
            found = 1'b1;
          end
        end
        if (hit >= 0) begin
          tbl_pkts[hit]++;
          // first matching watch register wins
          for (int w = 0; w < 4; w++) begin
            if (r.wclass == 3'd0 && watch_pid_m[w] == pid) begin
              watch_cnt[w]++;
              r.wclass = 3'(w + 1);
              r.wcount = watch_cnt[w];
            end
          end
          nxt = tbl_cc[hit] + 4'd1;
          if (nxt != cc && pid != ts_cc_pkg::NULL_PID) begin
            r.disc = 1'b1;
            tbl_discs[hit]++;
          end
          tbl_cc[hit] = cc;
          r.status = ts_cc_pkg::STAT_KNOWN;
          r.idx = 6'(hit);
          r.pid = pid;
          r.pkts = tbl_pkts[hit];
          r.discs = tbl_discs[hit];
        end else if (slot >= 0) begin
          tbl_valid[slot] = 1'b1;
          tbl_pid[slot] = pid;
          tbl_cc[slot] = cc;
          tbl_pkts[slot] = 32'd1;
          tbl_discs[slot] = 32'd0;
          r.status = ts_cc_pkg::STAT_NEW;
          r.idx = 6'(slot);
          r.pid = pid;
          r.pkts = 32'd1;
        end else begin
          r.status = ts_cc_pkg::STAT_FULL;
          r.pid = pid;
        end
        r.total = pkt_total;
      end
      ts_cc_pkg::CMD_CLEAR: begin
        for (int i = 0; i < TABLE_ENTRIES; i++) tbl_valid[i] = 1'b0;
        for (int w = 0; w < 4; w++) watch_cnt[w] = '0;
        pkt_total = '0;
        r.status = ts_cc_pkg::STAT_CLEARED;
      end
      ts_cc_pkg::CMD_READ: begin
        r.idx = ridx;
        r.total = pkt_total;
        if (tbl_valid[ridx]) begin
          r.status = ts_cc_pkg::STAT_RD_OK;
          r.pid = tbl_pid[ridx];
          r.pkts = tbl_pkts[ridx];
          r.discs = tbl_discs[ridx];
        end else begin
          r.status = ts_cc_pkg::STAT_RD_NONE;
        end
      end
      default: r.status = ts_cc_pkg::STAT_RD_NONE;
    endcase
    return r;
  endfunction

  function automatic ts_result_t mk_res(ts_cc_pkg::status_t st, int idx, int pid, int disc,
                                        int pk, int dc, int tot, int wc, int wn);
    ts_result_t r;
    r.status = st;
    r.idx = 6'(idx);
    r.pid = 13'(pid);
    r.disc = 1'(disc);
    r.pkts = 32'(pk);
    r.discs = 32'(dc);
    r.total = 32'(tot);
    r.wclass = 3'(wc);
    r.wcount = 32'(wn);
    return r;
  endfunction

  function automatic void add_row(ts_cc_pkg::cmd_t c, int pid, int cc, int ridx, bit typed,
                                  ts_result_t r);
    stim_row_t row;
    row.cmd = c;
    row.pid = 13'(pid);
    row.cc = 4'(cc);
    row.ridx = 6'(ridx);
    row.typed = typed;
    row.res = r;
    dir_rows.push_back(row);
  endfunction

  function automatic void cmp_field(string name, logic [31:0] e, logic [31:0] a);
    if (e !== a) begin
      errors++;
      if (errors <= MAX_REPORTS)
        $display("%0t ns: %s mismatch: expected %0h, actual %0h", $time, name, e, a);
    end
  endfunction

  // Predict on acceptance, then compare any strobed result with the oldest expectation
  always @(posedge clk) begin
    ts_result_t pred;
    ts_result_t exp_r;
    if (rst_n) begin
      if (cfg_we) watch_pid_m[cfg_index] = cfg_wdata;
      if (start && !busy) begin
        pred = cc_predict(ts_cc_pkg::cmd_t'(in_command), in_pid, in_cc, in_read_index);
        expected_results.push_back(cur_typed ? cur_res : pred);
      end
      if (out_valid) begin
        if (expected_results.size() == 0) begin
          errors++;
          if (errors <= MAX_REPORTS)
            $display("%0t ns: unexpected result: expected none, actual status %0d",
                     $time, out_status);
        end else begin
          exp_r = expected_results.pop_front();
          checked++;
          cmp_field("status", 32'(exp_r.status), 32'(out_status));
          cmp_field("entry_index", 32'(exp_r.idx), 32'(out_entry_index));
          cmp_field("entry_pid", 32'(exp_r.pid), 32'(out_entry_pid));
          cmp_field("discontinuity", 32'(exp_r.disc), 32'(out_discontinuity));
          cmp_field("entry_packets", exp_r.pkts, out_entry_packets);
          cmp_field("entry_discontinuities", exp_r.discs, out_entry_discontinuities);
          cmp_field("total_packets", exp_r.total, out_total_packets);
          cmp_field("watch_class", 32'(exp_r.wclass), 32'(out_watch_class));
          cmp_field("watch_count", exp_r.wcount, out_watch_count);
          case (exp_r.status)
            ts_cc_pkg::STAT_KNOWN:   n_known++;
            ts_cc_pkg::STAT_NEW:     n_new++;
            ts_cc_pkg::STAT_FULL:    n_full++;
            ts_cc_pkg::STAT_CLEARED: n_clears++;
            default:                 n_reads++;
          endcase
          if (exp_r.disc) n_disc++;
        end
      end
    end
  end

  // Present one transaction and hold it until the block takes it
  task automatic issue(ts_cc_pkg::cmd_t cmd, logic [12:0] pid, logic [3:0] cc,
                       logic [5:0] ridx, bit typed, ts_result_t r);
    @(negedge clk);
    start <= 1'b1;
    in_command <= cmd;
    in_pid <= pid;
    in_cc <= cc;
    in_read_index <= ridx;
    cur_typed <= typed;
    cur_res <= r;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic idle_gap(int n);
    @(negedge clk);
    start <= 1'b0;
    repeat (n - 1) @(negedge clk);
  endtask

  task automatic maybe_idle(int pct);
    if ($urandom_range(0, 99) < pct) idle_gap($urandom_range(1, 14));
  endtask

  // Drain all outstanding results, then give the block time to settle
  task automatic wait_quiet();
    @(negedge clk);
    start <= 1'b0;
    while (expected_results.size() != 0) @(negedge clk);
    repeat (TABLE_ENTRIES + 4) @(negedge clk);
  endtask

  task automatic write_watch(logic [12:0] a, logic [12:0] b, logic [12:0] c, logic [12:0] d);
    logic [12:0] v [4];
    v[0] = a;
    v[1] = b;
    v[2] = c;
    v[3] = d;
    for (int i = 0; i < 4; i++) begin
      @(negedge clk);
      cfg_we <= 1'b1;
      cfg_index <= 2'(i);
      cfg_wdata <= v[i];
    end
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    int sent;
    int psize;
    int idle_pct;
    int r;
    logic [12:0] pid;
    logic [3:0] cc;
    logic [12:0] wa, wb, wc, wd;
    ts_result_t none;

    none = '0;
    errors = 0;
    checked = 0;
    sent = 0;
    n_known = 0; n_new = 0; n_full = 0; n_reads = 0; n_clears = 0; n_disc = 0;
    rst_n = 1'b0;
    start = 1'b0;
    in_command = ts_cc_pkg::CMD_CHECK;
    in_pid = '0;
    in_cc = '0;
    in_read_index = '0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    cur_typed = 1'b0;
    cur_res = '0;
    pkt_total = '0;
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      tbl_valid[i] = 1'b0;
      tbl_pid[i] = '0;
      tbl_cc[i] = '0;
      tbl_pkts[i] = '0;
      tbl_discs[i] = '0;
    end
    for (int w = 0; w < 4; w++) begin
      watch_cnt[w] = '0;
      watch_pid_m[w] = '0;
    end
    for (int p = 0; p < 8192; p++) seq_cc[p] = 4'($urandom);

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    write_watch(13'h0100, ts_cc_pkg::NULL_PID, 13'h0000, 13'h1FFE);

    add_row(ts_cc_pkg::CMD_READ, 0, 0, 0, 1,
            mk_res(ts_cc_pkg::STAT_RD_NONE, 0, 0, 0, 0, 0, 0, 0, 0));
    add_row(ts_cc_pkg::CMD_READ, 'h1FFF, 15, 63, 1,
            mk_res(ts_cc_pkg::STAT_RD_NONE, 63, 0, 0, 0, 0, 0, 0, 0));
    add_row(ts_cc_pkg::CMD_NONE, 'h1FFF, 15, 63, 1,
            mk_res(ts_cc_pkg::STAT_RD_NONE, 0, 0, 0, 0, 0, 0, 0, 0));
    add_row(ts_cc_pkg::CMD_CHECK, 'h100, 5, 0, 1,
            mk_res(ts_cc_pkg::STAT_NEW, 0, 'h100, 0, 1, 0, 1, 0, 0));
    add_row(ts_cc_pkg::CMD_CHECK, 'h100, 6, 0, 1,
            mk_res(ts_cc_pkg::STAT_KNOWN, 0, 'h100, 0, 2, 0, 2, 1, 1));
    // repeated CC breaks the sequence
    add_row(ts_cc_pkg::CMD_CHECK, 'h100, 6, 0, 1,
            mk_res(ts_cc_pkg::STAT_KNOWN, 0, 'h100, 1, 3, 1, 3, 1, 2));
    add_row(ts_cc_pkg::CMD_CHECK, 'h1FFF, 15, 0, 1,
            mk_res(ts_cc_pkg::STAT_NEW, 1, 'h1FFF, 0, 1, 0, 4, 0, 0));
    // null PID never flags a discontinuity
    add_row(ts_cc_pkg::CMD_CHECK, 'h1FFF, 3, 0, 1,
            mk_res(ts_cc_pkg::STAT_KNOWN, 1, 'h1FFF, 0, 2, 0, 5, 2, 1));
    add_row(ts_cc_pkg::CMD_CHECK, 0, 0, 0, 1,
            mk_res(ts_cc_pkg::STAT_NEW, 2, 0, 0, 1, 0, 6, 0, 0));
    add_row(ts_cc_pkg::CMD_CHECK, 0, 15, 0, 1,
            mk_res(ts_cc_pkg::STAT_KNOWN, 2, 0, 1, 2, 1, 7, 3, 1));
    // CC wraps from 15 to 0
    add_row(ts_cc_pkg::CMD_CHECK, 0, 0, 0, 1,
            mk_res(ts_cc_pkg::STAT_KNOWN, 2, 0, 0, 3, 1, 8, 3, 2));
    add_row(ts_cc_pkg::CMD_READ, 0, 0, 0, 1,
            mk_res(ts_cc_pkg::STAT_RD_OK, 0, 'h100, 0, 3, 1, 8, 0, 0));
    add_row(ts_cc_pkg::CMD_READ, 0, 0, 2, 0, none);
    add_row(ts_cc_pkg::CMD_READ, 0, 0, 3, 1,
            mk_res(ts_cc_pkg::STAT_RD_NONE, 3, 0, 0, 0, 0, 8, 0, 0));
    add_row(ts_cc_pkg::CMD_CLEAR, 'h1FFF, 15, 63, 1,
            mk_res(ts_cc_pkg::STAT_CLEARED, 0, 0, 0, 0, 0, 0, 0, 0));
    add_row(ts_cc_pkg::CMD_READ, 0, 0, 0, 1,
            mk_res(ts_cc_pkg::STAT_RD_NONE, 0, 0, 0, 0, 0, 0, 0, 0));
    add_row(ts_cc_pkg::CMD_CHECK, 'h100, 0, 0, 1,
            mk_res(ts_cc_pkg::STAT_NEW, 0, 'h100, 0, 1, 0, 1, 0, 0));
    add_row(ts_cc_pkg::CMD_CHECK, 'h100, 1, 0, 1,
            mk_res(ts_cc_pkg::STAT_KNOWN, 0, 'h100, 0, 2, 0, 2, 1, 1));
    add_row(ts_cc_pkg::CMD_CHECK, 'h1FFE, 15, 0, 1,
            mk_res(ts_cc_pkg::STAT_NEW, 1, 'h1FFE, 0, 1, 0, 3, 0, 0));
    add_row(ts_cc_pkg::CMD_CHECK, 'h1FFE, 0, 0, 1,
            mk_res(ts_cc_pkg::STAT_KNOWN, 1, 'h1FFE, 0, 2, 0, 4, 4, 1));
    add_row(ts_cc_pkg::CMD_CHECK, 'h0ABC, 9, 21, 0, none);
    add_row(ts_cc_pkg::CMD_CHECK, 'h0ABC, 3, 42, 0, none);
    add_row(ts_cc_pkg::CMD_CHECK, 'h1555, 10, 0, 0, none);
    add_row(ts_cc_pkg::CMD_READ, 'h0AAA, 5, 1, 0, none);

    foreach (dir_rows[k]) begin
      issue(dir_rows[k].cmd, dir_rows[k].pid, dir_rows[k].cc, dir_rows[k].ridx,
            dir_rows[k].typed, dir_rows[k].res);
      sent++;
      maybe_idle(30);
    end

    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      wait_quiet();
      case (ph % 4)
        0: psize = $urandom_range(1, 6);
        1: psize = $urandom_range(10, 40);
        2: psize = $urandom_range(66, 90);
        default: psize = $urandom_range(2, 12);
      endcase
      pid_pool.delete();
      for (int k = 0; k < psize; k++) begin
        r = $urandom_range(0, 9);
        if (r == 0) pid_pool.push_back(ts_cc_pkg::NULL_PID);
        else if (r == 1) pid_pool.push_back(13'h0000);
        else pid_pool.push_back(13'($urandom));
      end
      if (ph == 0) begin
        wa = '0; wb = '0; wc = '0; wd = '0;
      end else if (ph == 1) begin
        wa = ts_cc_pkg::NULL_PID;
        wb = ts_cc_pkg::NULL_PID;
        wc = ts_cc_pkg::NULL_PID;
        wd = ts_cc_pkg::NULL_PID;
      end else begin
        wa = pid_pool[$urandom_range(0, psize - 1)];
        wb = ($urandom_range(0, 3) == 0) ? wa : pid_pool[$urandom_range(0, psize - 1)];
        wc = pid_pool[$urandom_range(0, psize - 1)];
        wd = ($urandom_range(0, 3) == 0) ? wc : pid_pool[$urandom_range(0, psize - 1)];
      end
      write_watch(wa, wb, wc, wd);
      idle_pct = (ph == 3) ? 0 : 25;
      if (ph % 2 == 0) begin
        issue(ts_cc_pkg::CMD_CLEAR, 13'($urandom), 4'($urandom), 6'($urandom), 1'b0, none);
        sent++;
      end

      for (int k = 0; k < PHASE_ITEMS; k++) begin
        r = $urandom_range(0, 99);
        if (r < 82) begin
          // well-formed stream on a pool PID, occasionally broken
          pid = pid_pool[$urandom_range(0, psize - 1)];
          cc = ($urandom_range(0, 99) < 85) ? seq_cc[pid] : 4'($urandom);
          seq_cc[pid] = cc + 4'd1;
          issue(ts_cc_pkg::CMD_CHECK, pid, cc, 6'($urandom), 1'b0, none);
        end else if (r < 86) begin
          issue(ts_cc_pkg::CMD_CHECK, 13'($urandom), 4'($urandom), 6'($urandom), 1'b0, none);
        end else if (r < 94) begin
          issue(ts_cc_pkg::CMD_READ, 13'($urandom), 4'($urandom), 6'($urandom), 1'b0, none);
        end else if (r < 96) begin
          issue(ts_cc_pkg::CMD_CLEAR, 13'($urandom), 4'($urandom), 6'($urandom), 1'b0, none);
        end else if (r < 98) begin
          issue(ts_cc_pkg::CMD_NONE, 13'($urandom), 4'($urandom), 6'($urandom), 1'b0, none);
        end else begin
          issue(ts_cc_pkg::CMD_CHECK, ts_cc_pkg::NULL_PID, 4'($urandom), 6'($urandom),
                1'b0, none);
        end
        sent++;
        if (ph * PHASE_ITEMS + k < CALM_AFTER) maybe_idle(idle_pct);
      end
    end

    @(negedge clk);
    start <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (TABLE_ENTRIES + 4) @(posedge clk);

    $display("Sent %0d transactions, checked %0d results: %0d known, %0d new, %0d table full,",
             sent, checked, n_known, n_new, n_full);
    $display("  %0d reads or unused, %0d clears, %0d discontinuities flagged.",
             n_reads, n_clears, n_disc);
    if (errors == 0) begin
      $display("PASS ts_continuity_checker");
    end else begin
      $display("FAIL ts_continuity_checker");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("Timeout with %0d results outstanding", expected_results.size());
    $display("FAIL ts_continuity_checker");
    $finish;
  end

endmodule
